// ===== hw/rtl/rpr_pkg.sv =====
// Shared types and constants of the rotary position rotator.
`timescale 1ns / 1ps

package rpr_pkg;

  // Datapath width of the rotated pair: Q15.32 plus headroom for rotation growth.
  localparam int DW = 52;
  // Residual angle width in 0.32 turns, with headroom for the CORDIC walk.
  localparam int ZW = 34;
  // Guard bits below the Q15.16 point.
  localparam int GUARD = 16;
  // CORDIC gain compensation 0.60725... in Q0.31.
  localparam logic signed [31:0] GAIN_Q31 = 32'sd1304065748;

  // Input item kinds.
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_ROTATE = 1'b1;

  // One item in flight through the rotation stages.
  typedef struct packed {
    logic                 v;
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  // atan(2^-k) in 0.32 turns, truncated.
  function automatic logic [31:0] turn_atan(input logic [4:0] k);
    logic [31:0] a;
    case (k)
      5'd0:  a = 32'h2000_0000;
      5'd1:  a = 32'h12E4_051D;
      5'd2:  a = 32'h09FB_385B;
      5'd3:  a = 32'h0511_11D4;
      5'd4:  a = 32'h028B_0D43;
      5'd5:  a = 32'h0145_D7E1;
      5'd6:  a = 32'h00A2_F61E;
      5'd7:  a = 32'h0051_7C55;
      5'd8:  a = 32'h0028_BE53;
      5'd9:  a = 32'h0014_5F2F;
      5'd10: a = 32'h000A_2F98;
      5'd11: a = 32'h0005_17CC;
      5'd12: a = 32'h0002_8BE6;
      5'd13: a = 32'h0001_45F3;
      5'd14: a = 32'h0000_A2F9;
      5'd15: a = 32'h0000_517C;
      5'd16: a = 32'h0000_28BE;
      5'd17: a = 32'h0000_145F;
      5'd18: a = 32'h0000_0A2F;
      5'd19: a = 32'h0000_0517;
      5'd20: a = 32'h0000_028B;
      5'd21: a = 32'h0000_0145;
      5'd22: a = 32'h0000_00A2;
      5'd23: a = 32'h0000_0051;
      5'd24: a = 32'h0000_0028;
      5'd25: a = 32'h0000_0014;
      5'd26: a = 32'h0000_000A;
      5'd27: a = 32'h0000_0005;
      5'd28: a = 32'h0000_0002;
      5'd29: a = 32'h0000_0001;
      default: a = 32'h0000_0000;
    endcase
    return a;
  endfunction

endpackage

// ===== hw/rtl/rpr_if.sv =====
// Valid/ready channel interfaces of the rotary position rotator.
`timescale 1ns / 1ps

interface rpr_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [5:0]         pair_index;
  logic [31:0]        freq_value;
  logic [15:0]        position;
  logic signed [31:0] first_value;
  logic signed [31:0] second_value;

  modport source (output valid, kind, pair_index, freq_value, position, first_value,
                  second_value, input ready);
  modport sink (input valid, kind, pair_index, freq_value, position, first_value,
                second_value, output ready);
endinterface

interface rpr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] first_result;
  logic signed [31:0] second_result;

  modport source (output valid, first_result, second_result, input ready);
  modport sink (input valid, first_result, second_result, output ready);
endinterface

// ===== hw/rtl/rpr_front.sv =====
// Front stages: frequency table, phase and gain multiplies, quarter-turn step.
`timescale 1ns / 1ps

module rpr_front import rpr_pkg::*; #(
  parameter int MAX_PAIRS = 64,
  parameter int POS_BITS  = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     run,
  rpr_in_if.sink   in_chan,
  output cordic_t  d_out
);

  localparam int IDX_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;

  logic                 accept;
  logic [IDX_W+5:0]     idx_w;
  logic [IDX_W-1:0]     idx;
  logic                 in_range;
  logic [POS_BITS+15:0] pos_w;

  logic [31:0] freq_mem [MAX_PAIRS];

  // stage 1
  logic                 v1_r;
  logic [31:0]          rd_r;
  logic                 rng1_r;
  logic [POS_BITS-1:0]  pos1_r;
  logic signed [31:0]   a1_r;
  logic signed [31:0]   b1_r;

  // stage 2
  logic                 v2_r;
  logic [31:0]          phase2_r;
  logic signed [DW-1:0] x2_r;
  logic signed [DW-1:0] y2_r;
  logic [31:0]          freq1;
  logic [POS_BITS+31:0] phase_prod;
  logic signed [63:0]   gx;
  logic signed [63:0]   gy;
  logic signed [63:0]   gx_sh;
  logic signed [63:0]   gy_sh;

  // stage 3
  logic                 v3_r;
  logic signed [DW-1:0] x3_r;
  logic signed [DW-1:0] y3_r;
  logic signed [ZW-1:0] z3_r;
  logic [31:0]          qsum;
  logic [1:0]           quad;
  logic [31:0]          resid;
  logic signed [DW-1:0] x3_nxt;
  logic signed [DW-1:0] y3_nxt;

  assign in_chan.ready = run;
  assign accept        = in_chan.valid && run;
  assign idx_w         = {{IDX_W{1'b0}}, in_chan.pair_index};
  assign idx           = idx_w[IDX_W-1:0];
  assign in_range      = ({3'b000, in_chan.pair_index} < 9'(MAX_PAIRS));
  assign pos_w         = {{POS_BITS{1'b0}}, in_chan.position};

  // Table write on a load transfer; out-of-range loads are dropped.
  always_ff @(posedge clk) begin
    if (accept && (in_chan.kind == KIND_LOAD) && in_range) begin
      freq_mem[idx] <= in_chan.freq_value;
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      rd_r   <= freq_mem[idx];
      rng1_r <= in_range;
      pos1_r <= pos_w[POS_BITS-1:0];
      a1_r   <= in_chan.first_value;
      b1_r   <= in_chan.second_value;
    end
  end

  assign freq1      = rng1_r ? rd_r : 32'd0;
  assign phase_prod = pos1_r * freq1;
  assign gx         = a1_r * GAIN_Q31;
  assign gy         = b1_r * GAIN_Q31;
  assign gx_sh      = gx >>> (31 - GUARD);
  assign gy_sh      = gy >>> (31 - GUARD);

  always_ff @(posedge clk) begin
    if (run) begin
      phase2_r <= phase_prod[31:0];
      x2_r     <= gx_sh[DW-1:0];
      y2_r     <= gy_sh[DW-1:0];
    end
  end

  assign qsum  = phase2_r + 32'h2000_0000;
  assign quad  = qsum[31:30];
  assign resid = phase2_r - {quad, 30'd0};

  always_comb begin
    case (quad)
      2'd1: begin
        x3_nxt = -y2_r;
        y3_nxt = x2_r;
      end
      2'd2: begin
        x3_nxt = -x2_r;
        y3_nxt = -y2_r;
      end
      2'd3: begin
        x3_nxt = y2_r;
        y3_nxt = -x2_r;
      end
      default: begin
        x3_nxt = x2_r;
        y3_nxt = y2_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (run) begin
      x3_r <= x3_nxt;
      y3_r <= y3_nxt;
      z3_r <= {{(ZW-32){resid[31]}}, resid};
    end
  end

  // Valid bits; only rotate items carry a result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (run) begin
      v1_r <= accept && (in_chan.kind == KIND_ROTATE);
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign d_out.v = v3_r;
  assign d_out.x = x3_r;
  assign d_out.y = y3_r;
  assign d_out.z = z3_r;

endmodule

// ===== hw/rtl/rpr_cordic_stage.sv =====
// One registered CORDIC micro-rotation with a fixed shift.
`timescale 1ns / 1ps

module rpr_cordic_stage import rpr_pkg::*; #(
  parameter int K = 0
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    run,
  input  cordic_t d_in,
  output cordic_t d_out
);

  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic signed [ZW-1:0] ang;
  logic signed [DW-1:0] x_nxt;
  logic signed [DW-1:0] y_nxt;
  logic signed [ZW-1:0] z_nxt;
  logic                 v_r;
  logic signed [DW-1:0] x_r;
  logic signed [DW-1:0] y_r;
  logic signed [ZW-1:0] z_r;

  assign dx  = d_in.y >>> K;
  assign dy  = d_in.x >>> K;
  assign ang = $signed({{(ZW-32){1'b0}}, turn_atan(5'(K))});

  always_comb begin
    if (!d_in.z[ZW-1]) begin
      x_nxt = d_in.x - dx;
      y_nxt = d_in.y + dy;
      z_nxt = d_in.z - ang;
    end else begin
      x_nxt = d_in.x + dx;
      y_nxt = d_in.y - dy;
      z_nxt = d_in.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (run) begin
      v_r <= d_in.v;
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign d_out.v = v_r;
  assign d_out.x = x_r;
  assign d_out.y = y_r;
  assign d_out.z = z_r;

endmodule

// ===== hw/rtl/rpr_out.sv =====
// Round and saturate to Q15.16, output register and skid register.
`timescale 1ns / 1ps

module rpr_out import rpr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cordic_t   d_in,
  output logic      run,
  rpr_out_if.source out_chan
);

  localparam int RW = DW - GUARD;

  logic signed [31:0] rx;
  logic signed [31:0] ry;
  logic               out_v_r;
  logic signed [31:0] out_a_r;
  logic signed [31:0] out_b_r;
  logic               skid_v_r;
  logic signed [31:0] skid_a_r;
  logic signed [31:0] skid_b_r;

  function automatic logic signed [31:0] round_sat(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] s;
    logic signed [RW-1:0] r;
    logic signed [31:0]   o;
    s = (v + $signed(DW'(1) <<< (GUARD - 1))) >>> GUARD;
    r = s[RW-1:0];
    if (r[RW-1:31] == {(RW-31){1'b0}} || r[RW-1:31] == {(RW-31){1'b1}}) begin
      o = r[31:0];
    end else if (r[RW-1]) begin
      o = 32'sh8000_0000;
    end else begin
      o = 32'sh7FFF_FFFF;
    end
    return o;
  endfunction

  assign rx  = round_sat(d_in.x);
  assign ry  = round_sat(d_in.y);
  // Advance the pipeline whenever the skid register is free.
  assign run = !skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_chan.ready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r  <= d_in.v;
      end
    end else if (run && d_in.v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_chan.ready) begin
      if (skid_v_r) begin
        out_a_r <= skid_a_r;
        out_b_r <= skid_b_r;
      end else begin
        out_a_r <= rx;
        out_b_r <= ry;
      end
    end else if (run && d_in.v) begin
      skid_a_r <= rx;
      skid_b_r <= ry;
    end
  end

  assign out_chan.valid         = out_v_r;
  assign out_chan.first_result  = out_a_r;
  assign out_chan.second_result = out_b_r;

endmodule

// ===== hw/rtl/rotary_position_rotator_core.sv =====
// Top level of the rotary position rotator: front stages, CORDIC chain, output.
//
// Usage: in_chan carries load and rotate items on a valid/ready transfer.
// A load item (kind 0) writes freq_value into the frequency entry of
// pair_index and gives no result; indexes of MAX_PAIRS and above are dropped.
// A rotate item (kind 1) forms phase = position * frequency (mod one turn),
// rotates (first_value, second_value) by it and gives one result on out_chan,
// rounded and saturated to Q15.16. Results leave in the order items entered.
// Path from transfer in to valid out: table read, phase and gain multiply,
// quarter-turn step, a register for each CORDIC micro-rotation, then the
// output register with rounding.
// Throughput: one item per cycle unless stalled; each stage is registered.
// Reset: clears all valid bits; the frequency table is undefined until loaded,
// so each entry must be loaded before a rotate reads it.
// Stall: when out_chan.ready is low, the waiting result holds and one more
// result drops into a skid register; in_chan.ready then falls and the whole
// pipeline holds until the skid register drains.
`timescale 1ns / 1ps

module rotary_position_rotator_core import rpr_pkg::*; #(
  parameter int MAX_PAIRS       = 64,
  parameter int POS_BITS        = 16,
  parameter int ROTATION_STAGES = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  rpr_in_if.sink    in_chan,
  rpr_out_if.source out_chan
);

  logic    run;
  cordic_t chain [ROTATION_STAGES + 1];

  // Table, multiplies and quarter-turn step.
  rpr_front #(
    .MAX_PAIRS (MAX_PAIRS),
    .POS_BITS  (POS_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .run     (run),
    .in_chan (in_chan),
    .d_out   (chain[0])
  );

  // One registered micro-rotation per stage; the shift grows by one each step.
  for (genvar i = 0; i < ROTATION_STAGES; i++) begin : g_cordic
    rpr_cordic_stage #(
      .K (i)
    ) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .run   (run),
      .d_in  (chain[i]),
      .d_out (chain[i+1])
    );
  end

  // Round, saturate and hand off; also decides when the pipeline advances.
  rpr_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .d_in     (chain[ROTATION_STAGES]),
    .run      (run),
    .out_chan (out_chan)
  );

endmodule

// ===== tb/tb_rotary_position_rotator_core.sv =====
// Testbench of the rotary position rotator: random and directed pairs against a bit-true predictor.
`timescale 1ns / 1ps

module tb_rotary_position_rotator_core import rpr_pkg::*; ();

  // Block configuration under test; the predictor follows the same values.
  localparam int PAIRS       = 64;
  localparam int STAGES      = 24;
  localparam int LATENCY     = STAGES + 3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PRINT_LIMIT = 30;

  // CORDIC gain 0.60725... in Q0.31, applied to both inputs on entry.
  localparam longint GAIN = 64'sd1304065748;

  // atan(2^-k) in 0.32 turns, truncated, one per micro-rotation.
  localparam logic [31:0] ATAN_TURNS [STAGES] = '{
    32'h2000_0000, 32'h12E4_051D, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9, 32'h0000_517C,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A2F, 32'h0000_0517,
    32'h0000_028B, 32'h0000_0145, 32'h0000_00A2, 32'h0000_0051
  };

  // One input item; hold_for_drain keeps it back until every result is out.
  typedef struct {
    logic               kind;
    logic [5:0]         pair_index;
    logic [31:0]        freq_value;
    logic [15:0]        position;
    logic signed [31:0] first_value;
    logic signed [31:0] second_value;
    bit                 hold_for_drain;
  } pair_item_t;

  typedef struct {
    logic signed [31:0] first_result;
    logic signed [31:0] second_result;
  } rotated_pair_t;

  logic clk = 1'b0;
  logic rst_n;

  rpr_in_if  in_bus ();
  rpr_out_if out_bus ();

  rotary_position_rotator_core #(
    .MAX_PAIRS      (PAIRS),
    .POS_BITS       (16),
    .ROTATION_STAGES(STAGES)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_bus),
    .out_chan(out_bus)
  );

  // Items waiting to be offered, and rotations waiting to come out.
  pair_item_t    pair_items[$];
  rotated_pair_t expected_pairs[$];

  // Frequency table as the predictor sees it, updated on each load transfer.
  logic [31:0] pair_freq [PAIRS];
  // Entries the stimulus has loaded so far; rotates only pick these.
  bit          gen_loaded [PAIRS];

  int send_idle_pct    = 0;
  int recv_stall_pct   = 0;
  int ready_hold_left  = 0;
  bit in_taken         = 1'b0;

  int cycle_count      = 0;
  int error_count      = 0;
  int loads_seen       = 0;
  int rotations_seen   = 0;
  int results_checked  = 0;
  int saturated_seen   = 0;
  int quadrant_hits [4] = '{0, 0, 0, 0};

  rotated_pair_t want;
  rotated_pair_t got;
  logic [1:0]    last_quad;

  // Clock: 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] seen,
                                 input logic [31:0] wanted);
    if (error_count < PRINT_LIMIT)
      $display("MISMATCH at cycle %0d: %s: got %h, expected %h", cycle_count, what, seen,
               wanted);
    error_count++;
  endtask

  // Predict one rotation: phase from position and frequency, quarter-turn
  // step, CORDIC on the residual, then round half up and saturate.
  function automatic rotated_pair_t compute_rotated_pair(
      input logic [31:0] freq, input logic [15:0] pos,
      input logic signed [31:0] first_in, input logic signed [31:0] second_in,
      output logic [1:0] quad);
    rotated_pair_t res;
    logic [47:0]   prod;
    logic [31:0]   phase;
    logic [31:0]   shifted;
    logic [31:0]   resid;
    longint        x, y, z, dx, dy, t, r;
    prod    = pos * freq;
    phase   = prod[31:0];
    shifted = phase + 32'h2000_0000;
    quad    = shifted[31:30];
    resid   = phase - {quad, 30'd0};
    z       = longint'($signed(resid));
    x       = (longint'(first_in) * GAIN) >>> 15;
    y       = (longint'(second_in) * GAIN) >>> 15;
    case (quad)
      2'd1: begin
        t = x; x = -y; y = t;
      end
      2'd2: begin
        x = -x; y = -y;
      end
      2'd3: begin
        t = x; x = y; y = -t;
      end
      default: ;
    endcase
    for (int k = 0; k < STAGES; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - longint'(ATAN_TURNS[k]);
      end else begin
        x = x + dx; y = y - dy; z = z + longint'(ATAN_TURNS[k]);
      end
    end
    r = (x + 64'sd32768) >>> 16;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    res.first_result = r[31:0];
    r = (y + 64'sd32768) >>> 16;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    res.second_result = r[31:0];
    return res;
  endfunction

  // Driver: present the next item at the falling edge; hold it until the
  // transfer, and roll for a sender gap only between items.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_taken) begin
      in_taken = 1'b0;
      if (pair_items.size() != 0 &&
          !(pair_items[0].hold_for_drain && expected_pairs.size() != 0) &&
          $urandom_range(99) >= send_idle_pct) begin
        in_bus.valid        <= 1'b1;
        in_bus.kind         <= pair_items[0].kind;
        in_bus.pair_index   <= pair_items[0].pair_index;
        in_bus.freq_value   <= pair_items[0].freq_value;
        in_bus.position     <= pair_items[0].position;
        in_bus.first_value  <= pair_items[0].first_value;
        in_bus.second_value <= pair_items[0].second_value;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Receiver: a requested hold-off is counted down here; otherwise stall at
  // the rate of the current profile.
  always @(negedge clk) begin
    if (ready_hold_left > 0) begin
      out_bus.ready   <= 1'b0;
      ready_hold_left <= ready_hold_left - 1;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: sample both channels at the rising edge. An input transfer
  // updates the predictor; an output transfer is checked against the oldest
  // expectation.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending", cycle_count,
               expected_pairs.size());
      $display("RESULT: ERROR");
      $finish;
    end else if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        in_taken = 1'b1;
        void'(pair_items.pop_front());
        if (in_bus.kind == KIND_LOAD) begin
          // Loads beyond the table are dropped.
          if (in_bus.pair_index < PAIRS)
            pair_freq[in_bus.pair_index] = in_bus.freq_value;
          loads_seen++;
        end else begin
          // A rotate beyond the table rotates by nothing.
          want = compute_rotated_pair(
              (in_bus.pair_index < PAIRS) ? pair_freq[in_bus.pair_index] : 32'd0,
              in_bus.position, in_bus.first_value, in_bus.second_value, last_quad);
          expected_pairs.push_back(want);
          quadrant_hits[last_quad]++;
          rotations_seen++;
        end
      end
      if (out_bus.valid && out_bus.ready) begin
        got.first_result  = out_bus.first_result;
        got.second_result = out_bus.second_result;
        if (expected_pairs.size() == 0) begin
          report_mismatch("result with no rotation pending", got.first_result, 32'd0);
        end else begin
          want = expected_pairs.pop_front();
          if (got.first_result !== want.first_result)
            report_mismatch("first_result", got.first_result, want.first_result);
          if (got.second_result !== want.second_result)
            report_mismatch("second_result", got.second_result, want.second_result);
          if (want.first_result == 32'sh7FFF_FFFF || want.first_result == 32'sh8000_0000 ||
              want.second_result == 32'sh7FFF_FFFF || want.second_result == 32'sh8000_0000)
            saturated_seen++;
          results_checked++;
        end
      end
    end
  end

  // Stimulus helpers. Fields an item does not use carry random junk.
  task automatic push_load(input int idx, input logic [31:0] freq, input bit hold);
    pair_item_t item;
    item.kind           = KIND_LOAD;
    item.pair_index     = idx[5:0];
    item.freq_value     = freq;
    item.position       = 16'($urandom_range(65535));
    item.first_value    = $urandom;
    item.second_value   = $urandom;
    item.hold_for_drain = hold;
    pair_items.push_back(item);
    gen_loaded[idx]     = 1'b1;
  endtask

  task automatic push_rotate(input int idx, input logic [15:0] pos,
                             input logic signed [31:0] first_in,
                             input logic signed [31:0] second_in, input bit hold);
    pair_item_t item;
    item.kind           = KIND_ROTATE;
    item.pair_index     = idx[5:0];
    item.freq_value     = $urandom;
    item.position       = pos;
    item.first_value    = first_in;
    item.second_value   = second_in;
    item.hold_for_drain = hold;
    pair_items.push_back(item);
  endtask

  function automatic logic signed [31:0] rand_value();
    logic signed [31:0] corner_vals [6] = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0,
                                            -32'sh1, 32'sh1_0000, -32'sh1_0000};
    case ($urandom_range(7))
      0:       return corner_vals[$urandom_range(5)];
      1, 2:    return 32'(int'($urandom_range(0, 1048575)) - 524288);
      3:       return 32'(int'($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000) <<< 7;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_freq();
    logic [31:0] corner_freqs [6] = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h4000_0000,
                                      32'h2000_0000, 32'h1FFF_FFFF};
    case ($urandom_range(5))
      0:          return corner_freqs[$urandom_range(5)];
      1, 2, 3:    return $urandom >> $urandom_range(4, 28);   // realistic slow rates
      default:    return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_pos();
    case ($urandom_range(4))
      0:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      1, 2:    return 16'($urandom_range(4095));
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // Queue random items: a quarter loads, often chased by a rotate of the same
  // entry; rotates only read loaded entries. With pause_every set, every so
  // many items wait for the pipeline to empty before going in.
  task automatic add_random(input int count, input int pause_every);
    int n;
    int idx;
    int since_pause;
    bit hold;
    n           = 0;
    since_pause = 0;
    while (n < count) begin
      hold = (pause_every > 0) && (since_pause >= pause_every);
      if (hold) since_pause = 0;
      if ($urandom_range(3) == 0) begin
        idx = $urandom_range(PAIRS - 1);
        push_load(idx, rand_freq(), hold);
        n++;
        since_pause++;
        if ($urandom_range(2) == 0) begin
          push_rotate(idx, rand_pos(), rand_value(), rand_value(), 1'b0);
          n++;
          since_pause++;
        end
      end else begin
        do idx = $urandom_range(PAIRS - 1); while (!gen_loaded[idx]);
        push_rotate(idx, rand_pos(), rand_value(), rand_value(), hold);
        n++;
        since_pause++;
      end
    end
  endtask

  task automatic drain_all();
    while (pair_items.size() != 0 || expected_pairs.size() != 0) @(posedge clk);
  endtask

  initial begin
    rst_n                = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.kind          = KIND_LOAD;
    in_bus.pair_index    = '0;
    in_bus.freq_value    = '0;
    in_bus.position      = '0;
    in_bus.first_value   = '0;
    in_bus.second_value  = '0;
    out_bus.ready        = 1'b0;
    for (int i = 0; i < PAIRS; i++) begin
      pair_freq[i]  = '0;
      gen_loaded[i] = 1'b0;
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, no idling. Load the turning points of the phase first.
    push_load(0, 32'h0000_0000, 1'b0);     // no rotation
    push_load(63, 32'hFFFF_FFFF, 1'b0);    // largest rate, all bits set
    push_load(1, 32'h2000_0000, 1'b0);     // one eighth turn: quadrant boundary
    push_load(2, 32'h4000_0000, 1'b0);     // quarter turn
    push_load(3, 32'h8000_0000, 1'b0);     // half turn
    push_load(4, 32'hC000_0000, 1'b0);     // three quarters
    push_load(5, 32'h1FFF_FFFF, 1'b0);     // just below the boundary
    push_rotate(0, 16'hFFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
    push_rotate(63, 16'hFFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
    push_rotate(63, 16'h0000, -32'sh1, 32'sh1, 1'b0);
    // Forty-five degrees on full-scale pairs: the sum saturates both ways.
    push_rotate(1, 16'h0001, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
    push_rotate(1, 16'h0001, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
    push_rotate(2, 16'h0001, 32'sh0001_0000, 32'sh0, 1'b0);
    push_rotate(3, 16'h0001, 32'sh0001_0000, -32'sh1_0000, 1'b0);
    push_rotate(4, 16'h0001, 32'sh7FFF_FFFF, 32'sh0, 1'b0);
    push_rotate(5, 16'h0001, 32'sd12345, -32'sd54321, 1'b0);
    push_rotate(1, 16'h0003, 32'sh0123_4567, -32'sh0765_4321, 1'b0);
    // Phase wraps many turns at the largest position.
    push_rotate(2, 16'hFFFF, rand_value(), rand_value(), 1'b0);
    // Rotate right behind the load of its entry, then overwrite the entry.
    push_load(7, 32'h00AB_CDEF, 1'b0);
    push_rotate(7, 16'h1234, 32'sh0040_0000, -32'sh0020_0000, 1'b0);
    push_load(7, 32'h5555_5555, 1'b0);
    push_rotate(7, 16'hAAAA, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
    push_rotate(5, 16'h8000, 32'sh0, 32'sh0, 1'b0);
    drain_all();

    // Random part, one idle/stall profile after another.
    add_random(300, 0);
    drain_all();

    send_idle_pct = 86;
    add_random(250, 0);
    drain_all();

    send_idle_pct  = 0;
    recv_stall_pct = 86;
    add_random(250, 0);
    drain_all();

    // Light idling on both sides; now and then hold the sender until empty.
    send_idle_pct  = 27;
    recv_stall_pct = 27;
    add_random(250, 60);
    drain_all();

    // Long receiver hold-off while the sender keeps offering: fill the
    // pipeline and the skid register so the input stalls.
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    ready_hold_left = 300;
    add_random(150, 0);
    drain_all();

    repeat (LATENCY + 20) @(posedge clk);
    if (expected_pairs.size() != 0)
      report_mismatch("rotations never delivered", expected_pairs.size(), 32'd0);

    $display("Covered %0d loads and %0d rotations: free-running, sender gaps, %s",
             loads_seen, rotations_seen, "receiver stalls, mixed and a long hold-off.");
    $display("Checked %0d results (%0d saturated); quadrants hit %0d/%0d/%0d/%0d.",
             results_checked, saturated_seen, quadrant_hits[0], quadrant_hits[1],
             quadrant_hits[2], quadrant_hits[3]);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/rpr_pkg.sv
hw/rtl/rpr_if.sv
hw/rtl/rpr_front.sv
hw/rtl/rpr_cordic_stage.sv
hw/rtl/rpr_out.sv
hw/rtl/rotary_position_rotator_core.sv
tb/tb_rotary_position_rotator_core.sv
